/* sv/brle_pkg.sv */
// Shared types and constants for the binary run-length encoder.
package brle_pkg;

    // Widest run length count that the block emits.
    localparam int unsigned MAX_COUNT_WIDTH = 8;

    // Width of the configured count width field and its reset value.
    localparam int unsigned CW_FIELD_W = 4;
    localparam logic [CW_FIELD_W-1:0] CW_RESET = 4'd4;

    // Width of the symbol value field and of the run counter.
    localparam int unsigned VALUE_W = 8;

    // Result queue depth: one input beat yields at most three symbols.
    localparam int unsigned QDEPTH = 3;
    localparam int unsigned QCNT_W = 2;

    // Symbol kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               eoc;
    } sym_t;

endpackage

/* sv/binary_run_length_encoder_unit.sv */
// Binary run-length encoder with fixed-width counts: top level.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------------------
//   in      | in  | in_valid / in_stall | in_bit, is_last
//   out     | out | out_valid/out_stall | symbol_kind, symbol_value, end_of_code
//   cfg     | in  | cfg_we              | cfg_wdata (count width)
//
// One input beat per cycle while in_stall is low. Each beat is encoded in
// the cycle it is taken and its zero to three symbols land in a three-entry
// result queue that drains one symbol per cycle while out_stall is low, the
// first one presented in the cycle after the beat. A beat that yields more
// than one symbol stalls the input while they drain. The input is taken
// whenever the queue is empty or its last symbol leaves in the same cycle.
// Reset clears the run state and the queue and sets the count width to 4.
module binary_run_length_encoder_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic [brle_pkg::CW_FIELD_W-1:0] cfg_wdata,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         in_bit,
    input  logic                         is_last,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         symbol_kind,
    output logic [brle_pkg::VALUE_W-1:0] symbol_value,
    output logic                         end_of_code
);

    logic [brle_pkg::CW_FIELD_W-1:0] count_width_reg;
    logic                            started_reg, started_next;
    logic                            run_bit_reg, run_bit_next;
    logic [brle_pkg::VALUE_W-1:0]    run_count_reg, run_count_next;

    brle_pkg::sym_t                  q_reg [brle_pkg::QDEPTH];
    brle_pkg::sym_t                  q_next [brle_pkg::QDEPTH];
    logic [brle_pkg::QCNT_W-1:0]     qcnt_reg, qcnt_next;

    brle_pkg::sym_t                  res [brle_pkg::QDEPTH];
    logic [brle_pkg::QCNT_W-1:0]     res_n;

    logic [brle_pkg::CW_FIELD_W-1:0] eff_w;
    logic [brle_pkg::VALUE_W:0]      max_wide;
    logic [brle_pkg::VALUE_W-1:0]    maxc;
    logic [brle_pkg::VALUE_W-1:0]    sat_count;
    logic                            in_accept;
    logic                            out_accept;

    // Hold the count width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_width_reg <= brle_pkg::CW_RESET;
        end
        else if (cfg_we)
        begin
            count_width_reg <= cfg_wdata;
        end
    end

    // Clamp the width and form the largest count.
    always_comb
    begin
        eff_w = count_width_reg;
        if (eff_w == '0)
        begin
            eff_w = brle_pkg::CW_FIELD_W'(1);
        end
        if (eff_w > brle_pkg::CW_FIELD_W'(brle_pkg::MAX_COUNT_WIDTH))
        begin
            eff_w = brle_pkg::CW_FIELD_W'(brle_pkg::MAX_COUNT_WIDTH);
        end
        max_wide  = ((brle_pkg::VALUE_W+1)'(1) << eff_w) - (brle_pkg::VALUE_W+1)'(1);
        maxc      = max_wide[brle_pkg::VALUE_W-1:0];
        sat_count = (run_count_reg > maxc) ? maxc : run_count_reg;
    end

    // Handshakes: take a beat when the queue is empty or empties this cycle.
    assign out_valid  = (qcnt_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (qcnt_reg > brle_pkg::QCNT_W'(1)) ||
                        ((qcnt_reg == brle_pkg::QCNT_W'(1)) && out_stall);
    assign in_accept  = in_valid && !in_stall;

    // Encode one beat: symbols and next run state.
    always_comb
    begin
        for (int i = 0; i < brle_pkg::QDEPTH; i++)
        begin
            res[i] = '{kind: brle_pkg::KIND_COUNT, value: '0, eoc: 1'b0};
        end
        res_n          = '0;
        started_next   = started_reg;
        run_bit_next   = run_bit_reg;
        run_count_next = run_count_reg;

        priority if (!started_reg)
        begin
            res[0]         = '{kind: brle_pkg::KIND_START,
                               value: brle_pkg::VALUE_W'(in_bit), eoc: 1'b0};
            res_n          = brle_pkg::QCNT_W'(1);
            started_next   = 1'b1;
            run_bit_next   = in_bit;
            run_count_next = brle_pkg::VALUE_W'(1);
        end
        else if (in_bit == run_bit_reg)
        begin
            if (run_count_reg < maxc)
            begin
                run_count_next = run_count_reg + brle_pkg::VALUE_W'(1);
            end
            else
            begin
                // Saturated run: emit the maximum, an empty run, restart at one.
                res[0]         = '{kind: brle_pkg::KIND_COUNT, value: maxc, eoc: 1'b0};
                res[1]         = '{kind: brle_pkg::KIND_COUNT, value: '0, eoc: 1'b0};
                res_n          = brle_pkg::QCNT_W'(2);
                run_count_next = brle_pkg::VALUE_W'(1);
            end
        end
        else
        begin
            res[0]         = '{kind: brle_pkg::KIND_COUNT, value: sat_count, eoc: 1'b0};
            res_n          = brle_pkg::QCNT_W'(1);
            run_bit_next   = in_bit;
            run_count_next = brle_pkg::VALUE_W'(1);
        end

        // Close the stream: the new count never exceeds the maximum here.
        if (is_last)
        begin
            res[res_n]     = '{kind: brle_pkg::KIND_COUNT, value: run_count_next, eoc: 1'b1};
            res_n          = res_n + brle_pkg::QCNT_W'(1);
            started_next   = 1'b0;
            run_bit_next   = 1'b0;
            run_count_next = '0;
        end
    end

    // Advance the result queue: drop the head when the output takes it, load new symbols on a taken beat.
    always_comb
    begin
        q_next    = q_reg;
        qcnt_next = qcnt_reg;
        if (out_accept)
        begin
            for (int i = 0; i < brle_pkg::QDEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            qcnt_next = qcnt_reg - brle_pkg::QCNT_W'(1);
        end
        if (in_accept)
        begin
            q_next    = res;
            qcnt_next = res_n;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            run_bit_reg   <= 1'b0;
            run_count_reg <= '0;
            qcnt_reg      <= '0;
        end
        else
        begin
            qcnt_reg <= qcnt_next;
            if (in_accept)
            begin
                started_reg   <= started_next;
                run_bit_reg   <= run_bit_next;
                run_count_reg <= run_count_next;
            end
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign symbol_kind  = q_reg[0].kind;
    assign symbol_value = q_reg[0].value;
    assign end_of_code  = q_reg[0].eoc;

`ifndef ASSERT_OFF
    a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= brle_pkg::QCNT_W'(brle_pkg::QDEPTH))
        else $error("result queue count out of range");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (qcnt_reg == '0) ||
                      ((qcnt_reg == brle_pkg::QCNT_W'(1)) && out_accept))
        else $error("input beat taken while queue still holds symbols");

    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (run_count_reg == '0) && (run_bit_reg == 1'b0))
        else $error("run state not cleared between streams");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (run_count_reg != '0))
        else $error("empty run while a stream is open");

    a_eoc_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_code) |-> (qcnt_reg == brle_pkg::QCNT_W'(1)))
        else $error("end of code symbol is not the last queued symbol");
`endif

endmodule
